FILE: rtl/afs_pkg.sv
// Shared types, codes and sizes of the ADTS frame splitter.
package afs_pkg;

   localparam int HDR_BYTES       = 6;
   localparam int MIN_LEN         = 7;
   localparam int LEN_W           = 13;
   localparam int AFS_QUEUE_DEPTH = 4;

   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] SYNC_MASK   = 8'hF0;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_TRUNC = 2'd2;

   typedef enum logic [1:0] {
      OP_BYTE       = 2'd0,
      OP_STATUS     = 2'd1,
      OP_BYTE_TRUNC = 2'd2,
      OP_HEADER     = 2'd3
   } afs_op_type;

   typedef struct packed {
      afs_op_type             op;
      logic [HDR_BYTES*8-1:0] data;
      logic [LEN_W-1:0]       len;
      logic [1:0]             status;
      logic                   last;
   } afs_cmd_type;

endpackage

FILE: rtl/afs_front.sv
// Front end: sync hunt, header capture and classification of each input beat.
module afs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 stream_end,
   output logic                 push,
   output afs_pkg::afs_cmd_type cmd
);
   import afs_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'b001,
      PH_HEADER = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       prev_ff, prev_in;
   logic [LEN_W-1:0] seen_ff, seen_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       hold_ff [HDR_BYTES-1];
   logic             hold_we;
   logic [2:0]       hold_idx;
   logic [7:0]       hold_data;

   logic [LEN_W:0]   seen_next;
   logic [LEN_W-1:0] hdr_len;
   logic             body_last;
   logic             sync_hit;

   assign seen_next = {1'b0, seen_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign hdr_len   = {hold_ff[3][1:0], hold_ff[4], data_byte[7:5]};
   assign body_last = seen_next >= {1'b0, len_ff};
   assign sync_hit  = (prev_ff == SYNC_BYTE) && ((data_byte & SYNC_MASK) == SYNC_MASK);

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      seen_in    = seen_ff;
      len_in     = len_ff;
      hold_we    = 1'b0;
      hold_idx   = seen_ff[2:0];
      hold_data  = data_byte;
      push       = 1'b0;
      cmd.op     = OP_BYTE;
      cmd.data   = {{(HDR_BYTES*8-8){1'b0}}, data_byte};
      cmd.len    = len_ff;
      cmd.status = STATUS_OK;
      cmd.last   = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (seen_next[LEN_W-1:0] == LEN_W'(HDR_BYTES)) begin
                  len_in = hdr_len;
                  push   = 1'b1;
                  cmd.len = hdr_len;
                  if (hdr_len < LEN_W'(MIN_LEN)) begin
                     cmd.op     = OP_STATUS;
                     cmd.status = STATUS_SHORT;
                     phase_in   = PH_HUNT;
                     prev_in    = 8'd0;
                     seen_in    = '0;
                  end else if (stream_end) begin
                     cmd.op     = OP_STATUS;
                     cmd.status = STATUS_TRUNC;
                     phase_in   = PH_HUNT;
                     prev_in    = 8'd0;
                     seen_in    = '0;
                  end else begin
                     cmd.op   = OP_HEADER;
                     cmd.data = {data_byte, hold_ff[4], hold_ff[3], hold_ff[2],
                                 hold_ff[1], hold_ff[0]};
                     phase_in = PH_BODY;
                     seen_in  = LEN_W'(HDR_BYTES);
                  end
               end else if (stream_end) begin
                  push       = 1'b1;
                  cmd.op     = OP_STATUS;
                  cmd.len    = '0;
                  cmd.status = STATUS_TRUNC;
                  phase_in   = PH_HUNT;
                  prev_in    = 8'd0;
                  seen_in    = '0;
               end else begin
                  hold_we = 1'b1;
                  seen_in = seen_next[LEN_W-1:0];
               end
            end
            PH_BODY: begin
               push     = 1'b1;
               cmd.last = body_last;
               if (body_last) begin
                  phase_in = PH_HUNT;
                  prev_in  = 8'd0;
                  seen_in  = '0;
               end else if (stream_end) begin
                  cmd.op   = OP_BYTE_TRUNC;
                  phase_in = PH_HUNT;
                  prev_in  = 8'd0;
                  seen_in  = '0;
               end else begin
                  seen_in = seen_next[LEN_W-1:0];
               end
            end
            default: begin
               if (sync_hit) begin
                  if (stream_end) begin
                     push       = 1'b1;
                     cmd.op     = OP_STATUS;
                     cmd.len    = '0;
                     cmd.status = STATUS_TRUNC;
                     phase_in   = PH_HUNT;
                     prev_in    = 8'd0;
                     seen_in    = '0;
                  end else begin
                     hold_we  = 1'b1;
                     hold_idx = 3'd1;
                     seen_in  = LEN_W'(2);
                     len_in   = '0;
                     phase_in = PH_HEADER;
                     prev_in  = 8'd0;
                  end
               end else begin
                  phase_in = PH_HUNT;
                  prev_in  = stream_end ? 8'd0 : data_byte;
                  if (stream_end) begin
                     seen_in = '0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         prev_ff  <= 8'd0;
         seen_ff  <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         seen_ff  <= seen_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff[0] <= SYNC_BYTE;
      if (hold_we) begin
         hold_ff[hold_idx] <= hold_data;
      end
   end

endmodule

FILE: rtl/afs_queue.sv
// Short command queue between the front end and the result sequencer.
module afs_queue #(
   parameter int DEPTH = afs_pkg::AFS_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  afs_pkg::afs_cmd_type push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output afs_pkg::afs_cmd_type head
);
   import afs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   afs_cmd_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/afs_back.sv
// Back end: expands queued commands into result beats through an output register.
module afs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  afs_pkg::afs_cmd_type cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_frame_first,
   output logic                 rsp_frame_last,
   output logic [12:0]          rsp_frame_length,
   output logic [1:0]           rsp_status,
   output logic                 rsp_run_last
);
   import afs_pkg::*;

   logic [2:0]       idx_ff, idx_in;
   logic             load;
   logic             final_beat;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             bvalid_ff, bvalid_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0]       status_ff, status_in;
   logic             run_ff, run_in;

   assign load    = cmd_valid && (!valid_ff || !rsp_stall);
   assign cmd_pop = load && final_beat;

   always_comb begin
      byte_in    = cmd.data[7:0];
      bvalid_in  = 1'b1;
      first_in   = 1'b0;
      last_in    = 1'b0;
      len_in     = cmd.len;
      status_in  = STATUS_OK;
      run_in     = 1'b1;
      final_beat = 1'b1;
      case (cmd.op)
         OP_BYTE: begin
            last_in = cmd.last;
         end
         OP_STATUS: begin
            byte_in   = 8'd0;
            bvalid_in = 1'b0;
            status_in = cmd.status;
         end
         OP_BYTE_TRUNC: begin
            if (idx_ff == 3'd0) begin
               run_in     = 1'b0;
               final_beat = 1'b0;
            end else begin
               byte_in   = 8'd0;
               bvalid_in = 1'b0;
               status_in = STATUS_TRUNC;
            end
         end
         OP_HEADER: begin
            byte_in    = cmd.data[8*idx_ff +: 8];
            first_in   = idx_ff == 3'd0;
            final_beat = idx_ff == 3'(HDR_BYTES - 1);
            run_in     = final_beat;
         end
         default: begin
            final_beat = 1'b1;
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_beat ? 3'd0 : idx_ff + 3'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         len_ff    <= len_in;
         status_ff <= status_in;
         run_ff    <= run_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_frame_first  = first_ff;
   assign rsp_frame_last   = last_ff;
   assign rsp_frame_length = len_ff;
   assign rsp_status       = status_ff;
   assign rsp_run_last     = run_ff;

endmodule

FILE: rtl/adts_frame_splitter_core.sv
// ADTS frame splitter top level: front end, command queue and result sequencer.
//
// Accepts one stream byte per cycle while req_stall is low. The front end hunts
// for the 12-bit sync, captures the header until the 13-bit frame length is
// known and posts at most one command per byte into a QUEUE_DEPTH-entry queue;
// the back end turns each command into one, two or six result beats, one beat
// per cycle while rsp_stall is low, through a registered output. A frame's
// header releases six beats for the one byte that completes it, and frames are
// at least seven bytes, so the sustained rate is one byte per cycle while
// rsp_stall is low; req_stall rises only while the queue is full. A byte's
// first result goes through a queue slot and the output register to the outputs.
module adts_frame_splitter_core #(
   parameter int QUEUE_DEPTH = afs_pkg::AFS_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_first,
   output logic        rsp_frame_last,
   output logic [12:0] rsp_frame_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_last
);
   import afs_pkg::*;

   logic        accept;
   logic        push;
   afs_cmd_type push_cmd;
   afs_cmd_type head;
   logic        q_full;
   logic        q_not_empty;
   logic        pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   afs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .stream_end (req_stream_end),
      .push       (push),
      .cmd        (push_cmd)
   );

   afs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   afs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_not_empty),
      .cmd              (head),
      .cmd_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_first  (rsp_frame_first),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last)
   );

`ifndef SYNTH
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command posted into a full queue");

   a_status_only_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_status != STATUS_OK))
      else $error("status-only beat carries ok status");

   a_first_is_sync : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_first) |->
         (rsp_byte_valid && rsp_out_byte == SYNC_BYTE && !rsp_frame_last))
      else $error("frame start beat is not a sync byte");

   a_last_ends_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> (rsp_byte_valid && rsp_run_last))
      else $error("frame end beat does not close its run");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for the ADTS frame splitter: byte stream stimulus, beat prediction and checking.
`timescale 1ns / 100ps

module tb_top;
   import afs_pkg::*;

   localparam int unsigned RUN_LIMIT_NS = 4_000_000;
   localparam int unsigned SHOWN_ERRORS = 10;
   localparam int unsigned TAIL_CYCLES  = 20;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } split_phase_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             valid;
      logic             first;
      logic             last;
      logic [LEN_W-1:0] length;
      logic [1:0]       status;
      logic             run_last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_stream_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_first;
   logic        rsp_frame_last;
   logic [12:0] rsp_frame_length;
   logic [1:0]  rsp_status;
   logic        rsp_run_last;

   int unsigned req_idle_pct = 33;
   int unsigned rsp_stall_pct = 33;
   int unsigned bytes_sent = 0;
   int unsigned mismatch_count = 0;

   beat_type pending_beats[$];

   split_phase_type split_phase = PH_HUNT;
   logic [7:0]      prev_byte = 8'h00;
   logic [7:0]      hdr_hold[HDR_BYTES];
   int unsigned     taken_count = 0;
   int unsigned     known_len = 0;

   adts_frame_splitter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_stream_end   (req_stream_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_first  (rsp_frame_first),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic beat_type make_beat(input logic [7:0] data, input logic valid,
                                          input logic first, input logic last,
                                          input int unsigned len, input logic [1:0] status);
      beat_type bt;
      bt.data     = data;
      bt.valid    = valid;
      bt.first    = first;
      bt.last     = last;
      bt.length   = len[LEN_W-1:0];
      bt.status   = status;
      bt.run_last = 1'b0;
      return bt;
   endfunction

   task automatic restart_hunt();
      split_phase = PH_HUNT;
      prev_byte   = 8'h00;
      taken_count = 0;
   endtask

   // Work out the beats one accepted stream byte causes and queue them.
   task automatic split_stream_byte(input logic [7:0] b, input logic e);
      beat_type    run[$];
      beat_type    bt;
      int unsigned len;
      logic        is_last;
      if (split_phase == PH_HEADER) begin
         hdr_hold[taken_count < HDR_BYTES ? taken_count : HDR_BYTES - 1] = b;
         taken_count++;
         if (taken_count >= HDR_BYTES) begin
            len = {hdr_hold[3][1:0], hdr_hold[4], hdr_hold[5][7:5]};
            known_len = len;
            if (len < MIN_LEN) begin
               run.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, len, STATUS_SHORT));
               restart_hunt();
            end else if (e) begin
               run.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, len, STATUS_TRUNC));
               restart_hunt();
            end else begin
               for (int i = 0; i < HDR_BYTES; i++)
                  run.push_back(make_beat(hdr_hold[i], 1'b1, i == 0, 1'b0, len, STATUS_OK));
               split_phase = PH_BODY;
               taken_count = HDR_BYTES;
            end
         end else if (e) begin
            run.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, 0, STATUS_TRUNC));
            restart_hunt();
         end
      end else if (split_phase == PH_BODY) begin
         is_last = (taken_count + 1) >= known_len;
         run.push_back(make_beat(b, 1'b1, 1'b0, is_last, known_len, STATUS_OK));
         taken_count = (taken_count + 1) & 32'h1FFF;
         if (is_last) begin
            restart_hunt();
         end else if (e) begin
            run.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, known_len, STATUS_TRUNC));
            restart_hunt();
         end
      end else begin
         if (prev_byte == SYNC_BYTE && (b & SYNC_MASK) == SYNC_MASK) begin
            if (e) begin
               run.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, 0, STATUS_TRUNC));
               restart_hunt();
            end else begin
               hdr_hold[0] = SYNC_BYTE;
               hdr_hold[1] = b;
               taken_count = 2;
               known_len   = 0;
               split_phase = PH_HEADER;
               prev_byte   = 8'h00;
            end
         end else if (e) begin
            restart_hunt();
         end else begin
            split_phase = PH_HUNT;
            prev_byte   = b;
         end
      end
      if (run.size() != 0) begin
         bt = run[run.size() - 1];
         bt.run_last = 1'b1;
         run[run.size() - 1] = bt;
      end
      foreach (run[i])
         pending_beats.push_back(run[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic e);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_stream_end <= e;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
      split_stream_byte(b, e);
   endtask

   // Send the first count bytes of a frame whose header carries len.
   task automatic send_frame(input int unsigned len, input int unsigned count, input logic e);
      logic [7:0]  img[HDR_BYTES];
      logic [12:0] l13;
      l13    = len[12:0];
      img[0] = SYNC_BYTE;
      img[1] = SYNC_MASK | 8'($urandom_range(15));
      img[2] = 8'($urandom);
      img[3] = {6'($urandom), l13[12:11]};
      img[4] = l13[10:3];
      img[5] = {l13[2:0], 5'($urandom)};
      for (int i = 0; i < count; i++)
         send_byte(i < HDR_BYTES ? img[i] : 8'($urandom), e && (i == count - 1));
   endtask

   task automatic run_random_streams(input int unsigned n_bytes);
      int unsigned start;
      int unsigned len;
      int unsigned cnt;
      int unsigned r;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         r = $urandom_range(99);
         if (r < 60) begin
            len = $urandom_range(20, MIN_LEN);
            send_frame(len, len, $urandom_range(7) == 0);
         end else if (r < 72) begin
            len = $urandom_range(8191, MIN_LEN);
            cnt = $urandom_range(len < 12 ? len : 12, 1);
            send_frame(len, cnt, 1'b1);
         end else if (r < 82) begin
            len = $urandom_range(MIN_LEN - 1, 0);
            send_frame(len, HDR_BYTES, $urandom_range(1));
         end else begin
            repeat ($urandom_range(4, 1))
               send_byte(8'($urandom), $urandom_range(9) == 0);
         end
      end
   endtask

   task automatic test_directed_cases();
      send_byte(8'h00, 1'b1);
      send_frame(100, 2, 1'b1);
      send_frame(100, 3, 1'b1);
      send_frame(0, HDR_BYTES, 1'b1);
      send_frame(8191, HDR_BYTES, 1'b1);
      send_frame(MIN_LEN, MIN_LEN, 1'b1);
   endtask

   task automatic test_random_streams();
      run_random_streams(70);
   endtask

   task automatic test_full_rate();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random_streams(40);
      req_idle_pct  = 33;
      rsp_stall_pct = 33;
   endtask

   task automatic test_drain_pause();
      run_random_streams(10);
      // hold the sender until every queued beat has come out
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0)
         @(posedge clock);
      run_random_streams(15);
   endtask

   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.data     = rsp_out_byte;
         got.valid    = rsp_byte_valid;
         got.first    = rsp_frame_first;
         got.last     = rsp_frame_last;
         got.length   = rsp_frame_length;
         got.status   = rsp_status;
         got.run_last = rsp_run_last;
         if (pending_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
               $display("unexpected beat: byte %h bv %b first %b last %b len %0d st %0d rl %b",
                        got.data, got.valid, got.first, got.last, got.length, got.status,
                        got.run_last);
         end else begin
            want = pending_beats.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_ERRORS) begin
                  $display("mismatch exp: byte %h bv %b first %b last %b len %0d st %0d rl %b",
                           want.data, want.valid, want.first, want.last, want.length,
                           want.status, want.run_last);
                  $display("         got: byte %h bv %b first %b last %b len %0d st %0d rl %b",
                           got.data, got.valid, got.first, got.last, got.length,
                           got.status, got.run_last);
               end
            end
         end
      end
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_streams();
      test_full_rate();
      test_drain_pause();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_beats.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/afs_pkg.sv
rtl/afs_front.sv
rtl/afs_queue.sv
rtl/afs_back.sv
rtl/adts_frame_splitter_core.sv
test/tb_top.sv
